/* src/flt_pkg.sv */
// ----------------------------------------------------------------------------
// File header LRU table: shared definitions
// Table depth, index and rank types, the stored tag layout and the
// control groups that the sequencer sends to the two stores.
// ----------------------------------------------------------------------------
package flt_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int SLOT_W  = 6;

    localparam logic [7:0] KIND_DIR      = 8'h80;
    localparam logic [7:0] KIND_APPEND   = 8'h40;
    localparam logic [7:0] KIND_UNCACHED = KIND_DIR | KIND_APPEND;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [IDX_W-1:0] t_rank;

    localparam t_idx LAST_IDX = t_idx'(ENTRIES - 1);

    typedef struct packed {
        logic [63:0] path;
        logic [7:0]  kind;
        logic [31:0] version;
        logic [31:0] device;
        logic [15:0] device_kind;
    } t_tag;

    typedef struct packed {
        logic we;
        t_idx waddr;
        t_tag wdata;
        t_idx raddr;
    } t_tag_ctl;

    typedef struct packed {
        logic  we;
        t_idx  waddr;
        t_rank wdata;
        t_idx  raddr;
    } t_rank_ctl;

    typedef struct packed {
        logic              cacheable;
        logic [SLOT_W-1:0] slot;
        logic              hit;
        logic              version_changed;
        logic              replaced_valid;
    } t_result;

endpackage

/* src/flt_tag_store.sv */
// ----------------------------------------------------------------------------
// File header LRU table: tag store
// Single-write, single-read memory holding the tag of every slot, with a
// registered read port.
// ----------------------------------------------------------------------------
module flt_tag_store
    import flt_pkg::*;
(
    input  logic     i_clk,
    input  t_tag_ctl i_ctl,
    output t_tag     o_rd_data
);

    t_tag r_mem [ENTRIES];
    t_tag r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_ctl.waddr] <= i_ctl.wdata;
        end
        r_rd_data <= r_mem[i_ctl.raddr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* src/flt_rank_store.sv */
// ----------------------------------------------------------------------------
// File header LRU table: recency rank store
// Memory of one recency rank per slot. A slot whose rank has never been
// written reads back its own number, which is its rank after reset.
// ----------------------------------------------------------------------------
module flt_rank_store
    import flt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_rank_ctl i_ctl,
    output t_rank     o_rd_data
);

    t_rank              r_mem [ENTRIES];
    logic [ENTRIES-1:0] r_written;
    t_rank              r_rd_mem;
    t_idx               r_rd_addr;
    logic               r_rd_written;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
        end else if (i_ctl.we) begin
            r_written[i_ctl.waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_ctl.waddr] <= i_ctl.wdata;
        end
        r_rd_mem     <= r_mem[i_ctl.raddr];
        r_rd_addr    <= i_ctl.raddr;
        r_rd_written <= r_written[i_ctl.raddr];
    end

    assign o_rd_data = r_rd_written ? r_rd_mem : t_rank'(r_rd_addr);

endmodule

/* src/file_header_lru_table_core.sv */
// ----------------------------------------------------------------------------
// File header LRU table: top level
// A cacheable request makes one pass over the tag and rank memories, one
// slot a cycle, to find the matching slot and the least recent slot, and a
// second pass rewrites every recency rank through the single write port of
// the rank memory. A request whose kind bits mark a directory or an
// append-only file leaves the table untouched and goes straight to the
// finishing state, which gives its all-zero result. One request is in work
// at a time; a new request may be accepted while the previous result still
// waits to be taken.
// ----------------------------------------------------------------------------
module file_header_lru_table_core
    import flt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [63:0]       i_file_path,
    input  logic [7:0]        i_file_kind,
    input  logic [31:0]       i_file_version,
    input  logic [31:0]       i_device_number,
    input  logic [15:0]       i_device_kind,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_cacheable,
    output logic [SLOT_W-1:0] o_slot,
    output logic              o_hit,
    output logic              o_version_changed,
    output logic              o_replaced_valid
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_DECIDE,
        S_UPDATE,
        S_FINISH
    } t_state;

    t_state             r_state;
    t_tag               r_req;
    logic [ENTRIES-1:0] r_valid;
    t_idx               r_addr;
    logic               r_iss;
    logic               r_chk;
    t_idx               r_chk_addr;
    logic               r_found;
    t_idx               r_hit_slot;
    t_rank              r_hit_rank;
    logic [31:0]        r_hit_ver;
    logic               r_vic_seen;
    t_idx               r_vic_slot;
    logic               r_vic_valid;
    t_idx               r_slot;
    t_rank              r_old;
    t_result            r_work;
    t_result            r_res;
    logic               r_out_valid;

    t_tag_ctl  tag_ctl;
    t_rank_ctl rank_ctl;
    t_tag      tag_rd;
    t_rank     rank_rd;
    logic      in_acc;
    logic      match;
    t_idx      sel_slot;

    flt_tag_store u_tag_store (
        .i_clk     (i_clk),
        .i_ctl     (tag_ctl),
        .o_rd_data (tag_rd)
    );

    flt_rank_store u_rank_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (rank_ctl),
        .o_rd_data (rank_rd)
    );

    assign in_acc   = i_in_valid && o_in_ready;
    assign sel_slot = r_found ? r_hit_slot : r_vic_slot;

    assign match = r_valid[r_chk_addr]
                && (tag_rd.path == r_req.path)
                && (tag_rd.kind == r_req.kind)
                && (tag_rd.device == r_req.device)
                && (tag_rd.device_kind == r_req.device_kind);

    always_comb begin
        tag_ctl.we     = (r_state == S_DECIDE);
        tag_ctl.waddr  = sel_slot;
        tag_ctl.wdata  = r_req;
        tag_ctl.raddr  = r_addr;

        rank_ctl.we    = (r_state == S_UPDATE) && r_chk;
        rank_ctl.waddr = r_chk_addr;
        rank_ctl.raddr = r_addr;
        if (r_chk_addr == r_slot) begin
            rank_ctl.wdata = t_rank'(LAST_IDX);
        end else if (rank_rd > r_old) begin
            rank_ctl.wdata = rank_rd - t_rank'(1);
        end else begin
            rank_ctl.wdata = rank_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_iss       <= 1'b0;
            r_chk       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready && (r_state != S_FINISH)) begin
                r_out_valid <= 1'b0;
            end
            r_chk      <= r_iss;
            r_chk_addr <= r_addr;
            if (r_iss) begin
                r_addr <= r_addr + t_idx'(1);
                if (r_addr == LAST_IDX) begin
                    r_iss <= 1'b0;
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_req.path        <= i_file_path;
                        r_req.kind        <= i_file_kind;
                        r_req.version     <= i_file_version;
                        r_req.device      <= i_device_number;
                        r_req.device_kind <= i_device_kind;
                        if ((i_file_kind & KIND_UNCACHED) != 8'h00) begin
                            r_work  <= '0;
                            r_state <= S_FINISH;
                        end else begin
                            r_addr     <= '0;
                            r_iss      <= 1'b1;
                            r_found    <= 1'b0;
                            r_vic_seen <= 1'b0;
                            r_state    <= S_SEARCH;
                        end
                    end
                end
                S_SEARCH: begin
                    if (r_chk) begin
                        if (match && !r_found) begin
                            r_found    <= 1'b1;
                            r_hit_slot <= r_chk_addr;
                            r_hit_rank <= rank_rd;
                            r_hit_ver  <= tag_rd.version;
                        end
                        if (rank_rd == '0) begin
                            r_vic_seen  <= 1'b1;
                            r_vic_slot  <= r_chk_addr;
                            r_vic_valid <= r_valid[r_chk_addr];
                        end
                        if (r_chk_addr == LAST_IDX) begin
                            r_state <= S_DECIDE;
                        end
                    end
                end
                S_DECIDE: begin
                    r_valid[sel_slot]      <= 1'b1;
                    r_slot                 <= sel_slot;
                    r_old                  <= r_found ? r_hit_rank : '0;
                    r_work.cacheable       <= 1'b1;
                    r_work.slot            <= SLOT_W'(sel_slot);
                    r_work.hit             <= r_found;
                    r_work.version_changed <= r_found && (r_hit_ver != r_req.version);
                    r_work.replaced_valid  <= !r_found && r_vic_valid;
                    r_addr                 <= '0;
                    r_iss                  <= 1'b1;
                    r_state                <= S_UPDATE;
                end
                S_UPDATE: begin
                    if (r_chk && (r_chk_addr == LAST_IDX)) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_res       <= r_work;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready        = (r_state == S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_cacheable       = r_res.cacheable;
    assign o_slot            = r_res.slot;
    assign o_hit             = r_res.hit;
    assign o_version_changed = r_res.version_changed;
    assign o_replaced_valid  = r_res.replaced_valid;

    a_uncached_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_cacheable) |->
            (o_slot == '0) && !o_hit && !o_version_changed && !o_replaced_valid)
        else $error("Uncacheable request gave a non-zero result.");

    a_hit_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_hit && o_replaced_valid) && (!o_version_changed || o_hit))
        else $error("Inconsistent hit, version and replacement flags.");

    a_victim_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE) |-> (r_found || r_vic_seen))
        else $error("No matching slot and no least recent slot after search.");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_FINISH))
        else $error("Result raised outside the finishing state.");

    a_rank_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rank_ctl.we |-> !r_iss || (rank_ctl.raddr != rank_ctl.waddr))
        else $error("Rank read and write hit the same slot in one cycle.");

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// File header LRU table: self-checking testbench
// Sends file-open requests through the valid/ready input channel and checks
// every result against a behavioural copy of the table held here: tag match
// over all valid slots, least recent replacement and version refresh. The
// stimulus is a short directed sequence followed by random requests drawn
// from a shifting working set, so that hits, misses and evictions all occur.
// Both channels idle at random, the result side holds off once for a long
// stretch, and the sender stops one to three times until the table has gone idle.
// ----------------------------------------------------------------------------
module testbench;
    import flt_pkg::*;

    localparam int LIMIT_CYCLES = 600000;
    localparam int TAIL_CYCLES  = 2 * ENTRIES + 60;
    localparam int POOL_SIZE    = 96;
    localparam int RANDOM_COUNT = 935;
    localparam int LONG_HOLD    = 600;
    localparam int MAX_PRINTS   = 60;

    typedef struct {
        t_tag tag;
        bit   drain;
    } t_open_req;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [63:0]       file_path = '0;
    logic [7:0]        file_kind = '0;
    logic [31:0]       file_version = '0;
    logic [31:0]       device_number = '0;
    logic [15:0]       device_kind = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              cacheable;
    logic [SLOT_W-1:0] slot;
    logic              hit;
    logic              version_changed;
    logic              replaced_valid;

    t_open_req open_requests[$];
    t_result   lookup_results[$];
    t_open_req cur_req;
    t_result   predicted;
    t_result   want;

    bit   tab_valid[ENTRIES];
    t_tag tab_tag[ENTRIES];
    int   tab_rank[ENTRIES];
    t_tag pool[POOL_SIZE];

    int n_queued = 0;
    int n_accepted = 0;
    int n_results = 0;
    int n_errors = 0;
    int n_hits = 0;
    int n_new_version = 0;
    int n_misses = 0;
    int n_evictions = 0;
    int n_skipped = 0;
    int cycle_count = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int tx_wait = 0;
    int rx_wait = 0;
    bit offering = 1'b0;

    file_header_lru_table_core u_top (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_file_path      (file_path),
        .i_file_kind      (file_kind),
        .i_file_version   (file_version),
        .i_device_number  (device_number),
        .i_device_kind    (device_kind),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_cacheable      (cacheable),
        .o_slot           (slot),
        .o_hit            (hit),
        .o_version_changed(version_changed),
        .o_replaced_valid (replaced_valid)
    );

    always #10 clk = ~clk;

    function automatic t_result table_lookup(input t_tag req);
        t_result res;
        int      s;
        int      i;
        int      old_rank;
        bit      found;
        res = '0;
        s = 0;
        found = 1'b0;
        if ((req.kind & KIND_UNCACHED) != 8'h00) begin
            return res;
        end
        for (i = 0; i < ENTRIES; i++) begin
            if (!found && tab_valid[i] && tab_tag[i].path == req.path
                    && tab_tag[i].kind == req.kind && tab_tag[i].device == req.device
                    && tab_tag[i].device_kind == req.device_kind) begin
                s = i;
                found = 1'b1;
            end
        end
        res.cacheable = 1'b1;
        if (found) begin
            res.hit = 1'b1;
            if (tab_tag[s].version != req.version) begin
                tab_tag[s].version = req.version;
                res.version_changed = 1'b1;
            end
        end else begin
            for (i = 0; i < ENTRIES; i++) begin
                if (tab_rank[i] == 0) begin
                    s = i;
                end
            end
            res.replaced_valid = tab_valid[s];
            tab_valid[s] = 1'b1;
            tab_tag[s] = req;
        end
        old_rank = tab_rank[s];
        for (i = 0; i < ENTRIES; i++) begin
            if (tab_rank[i] > old_rank) begin
                tab_rank[i]--;
            end
        end
        tab_rank[s] = ENTRIES - 1;
        res.slot = SLOT_W'(s);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint exp_val);
        n_errors++;
        if (n_errors <= MAX_PRINTS) begin
            $display("mismatch on result %0d: %s is %0h, expected %0h",
                     n_results, what, got, exp_val);
        end
    endtask

    task automatic add_open(input logic [63:0] path, input logic [7:0] kind,
                            input logic [31:0] vers, input logic [31:0] dev,
                            input logic [15:0] dkind, input bit drain);
        t_open_req req;
        req.tag.path = path;
        req.tag.kind = kind;
        req.tag.version = vers;
        req.tag.device = dev;
        req.tag.device_kind = dkind;
        req.drain = drain;
        open_requests.push_back(req);
        n_queued++;
    endtask

    // Request driver.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            offering = 1'b0;
            tx_wait = 0;
        end else begin
            if (in_valid && in_ready) begin
                predicted = table_lookup(cur_req.tag);
                lookup_results.push_back(predicted);
                if (!predicted.cacheable) begin
                    n_skipped++;
                end else if (predicted.hit) begin
                    n_hits++;
                    if (predicted.version_changed) begin
                        n_new_version++;
                    end
                end else begin
                    n_misses++;
                    if (predicted.replaced_valid) begin
                        n_evictions++;
                    end
                end
                n_accepted++;
                offering = 1'b0;
                tx_wait = (((n_accepted / 100) % 4) == 3) ? 0 : $urandom_range(0, 8);
            end
            if (!offering) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                end else if (open_requests.size() > 0
                        && !(open_requests[0].drain && n_results != n_accepted)) begin
                    cur_req = open_requests.pop_front();
                    offering = 1'b1;
                    file_path <= cur_req.tag.path;
                    file_kind <= cur_req.tag.kind;
                    file_version <= cur_req.tag.version;
                    device_number <= cur_req.tag.device;
                    device_kind <= cur_req.tag.device_kind;
                end
            end
            in_valid <= offering;
        end
    end

    // Long hold-off on the result side, once the run is well under way.
    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && n_results >= 300) begin
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Result monitor.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (out_valid && out_ready) begin
                if (lookup_results.size() == 0) begin
                    report_mismatch("result with nothing outstanding", 1, 0);
                end else begin
                    want = lookup_results.pop_front();
                    if (cacheable !== want.cacheable)
                        report_mismatch("cacheable", cacheable, want.cacheable);
                    if (slot !== want.slot)
                        report_mismatch("slot", slot, want.slot);
                    if (hit !== want.hit)
                        report_mismatch("hit", hit, want.hit);
                    if (version_changed !== want.version_changed)
                        report_mismatch("version_changed", version_changed,
                                        want.version_changed);
                    if (replaced_valid !== want.replaced_valid)
                        report_mismatch("replaced_valid", replaced_valid,
                                        want.replaced_valid);
                end
                n_results++;
                rx_wait = (((n_results / 100) % 4) == 1) ? 0 : $urandom_range(0, 8);
            end else if (out_valid && rx_wait > 0) begin
                rx_wait--;
            end
            out_ready <= (rx_wait == 0) && (hold_left == 0);
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("[file_header_lru_table_core] ERROR");
            $finish;
        end
    end

    initial begin
        int          i;
        int          idx;
        int          roll;
        int          span;
        int          base;
        logic [7:0]  kind;
        logic [31:0] vers;
        for (i = 0; i < ENTRIES; i++) begin
            tab_valid[i] = 1'b0;
            tab_tag[i] = '0;
            tab_rank[i] = i;
        end

        // Directed requests: field extremes, hits with and without a new
        // version, near misses on each tag field and every uncacheable kind.
        add_open('0, 8'h00, '0, '0, '0, 1'b0);
        add_open('0, 8'h00, '0, '0, '0, 1'b0);
        add_open('0, 8'h00, 32'hFFFF_FFFF, '0, '0, 1'b0);
        add_open('1, 8'h3F, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
        add_open('1, 8'h3F, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFE, 1'b0);
        add_open('1, 8'h3F, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 1'b0);
        add_open('1, 8'h3E, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
        add_open(64'h7FFF_FFFF_FFFF_FFFF, 8'h3F, 32'h0, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
        add_open('1, KIND_DIR, 32'h0, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
        add_open('1, KIND_APPEND, 32'h0, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
        add_open('0, KIND_UNCACHED, '0, '0, '0, 1'b0);
        add_open('1, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
        add_open('1, 8'h3F, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
        add_open('1, 8'h3F, 32'h0, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
        add_open('0, 8'h00, 32'hFFFF_FFFF, '0, '0, 1'b1);

        for (i = 0; i < POOL_SIZE; i++) begin
            pool[i].path = {$urandom, $urandom};
            pool[i].kind = 8'($urandom) & ~KIND_UNCACHED;
            pool[i].version = $urandom;
            pool[i].device = $urandom;
            pool[i].device_kind = 16'($urandom);
            if (i % 6 == 1) begin
                pool[i] = pool[i - 1];
                case ((i / 6) % 4)
                    0: pool[i].path[$urandom_range(0, 63)] ^= 1'b1;
                    1: pool[i].kind ^= 8'h01;
                    2: pool[i].device ^= 32'h8000_0000;
                    default: pool[i].device_kind ^= 16'h0001;
                endcase
            end
        end

        // Random requests from a working set that is sometimes small enough
        // to stay resident and sometimes larger than the table.
        for (i = 0; i < RANDOM_COUNT; i++) begin
            roll = $urandom_range(0, 99);
            span = (((i / 150) % 2) == 1) ? POOL_SIZE : 40;
            base = ((i / 300) * 17) % (POOL_SIZE - span + 1);
            idx = base + $urandom_range(0, span - 1);
            if (roll < 8) begin
                kind = 8'($urandom) | (($urandom_range(0, 2) == 0) ? KIND_UNCACHED :
                       (($urandom_range(0, 1) == 0) ? KIND_DIR : KIND_APPEND));
                if (roll < 4) begin
                    add_open(pool[idx].path, kind, pool[idx].version, pool[idx].device,
                             pool[idx].device_kind, 1'b0);
                end else begin
                    add_open({$urandom, $urandom}, kind, $urandom, $urandom,
                             16'($urandom), 1'b0);
                end
            end else if (roll < 13) begin
                add_open({$urandom, $urandom}, 8'($urandom) & ~KIND_UNCACHED, $urandom,
                         $urandom, 16'($urandom), 1'b0);
            end else begin
                if ($urandom_range(0, 9) < 4) begin
                    vers = (roll < 16) ? 32'hFFFF_FFFF : $urandom;
                    pool[idx].version = vers;
                end
                add_open(pool[idx].path, pool[idx].kind, pool[idx].version,
                         pool[idx].device, pool[idx].device_kind, (i % 350) == 349);
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        wait (n_accepted == n_queued && n_results == n_accepted);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (lookup_results.size() != 0) begin
            report_mismatch("results still outstanding", lookup_results.size(), 0);
        end

        $display("Covered %0d requests: %0d hits (%0d with a new version), %0d misses",
                 n_accepted, n_hits, n_new_version, n_misses);
        $display("of which %0d evicted a live entry, and %0d uncacheable requests; %0d errors",
                 n_evictions, n_skipped, n_errors);
        if (n_errors == 0) begin
            $display("[file_header_lru_table_core] OK");
        end else begin
            $display("[file_header_lru_table_core] ERROR");
        end
        $finish;
    end

endmodule

/* file_header_lru_table_core.f */
src/flt_pkg.sv
src/flt_tag_store.sv
src/flt_rank_store.sv
src/file_header_lru_table_core.sv
tb/testbench.sv
